>>> rtl/cia_pkg.sv
`default_nettype none

package cia_pkg;

   // field width on the ports
   localparam int DATA_BITS = 64;
   // default arithmetic width
   localparam int WORD_BITS_DEF = 64;

   // commands
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   // status codes
   localparam logic [1:0] ST_FITS     = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_INEXACT  = 2'd2;
   localparam logic [1:0] ST_DIVZERO  = 2'd3;

   typedef struct packed {
      logic [1:0]                  command;
      logic signed [DATA_BITS-1:0] operand_a;
      logic signed [DATA_BITS-1:0] operand_b;
      logic                        swap_operands;
      logic                        exact_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] result;
      logic signed [DATA_BITS-1:0] remainder;
      logic [1:0]                  status;
      logic                        exact_out;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/cia_div_step.sv
`default_nettype none

// One restoring division step: shift in one dividend bit, subtract if it fits.
module cia_div_step #(
   parameter int WORD_BITS = cia_pkg::WORD_BITS_DEF
) (
   input  wire logic [WORD_BITS-1:0] rem_i,
   input  wire logic [WORD_BITS-1:0] qs_i,
   input  wire logic [WORD_BITS-1:0] ud_i,
   output logic [WORD_BITS-1:0]      rem_o,
   output logic [WORD_BITS-1:0]      qs_o
);

   logic [WORD_BITS:0] trial;
   logic [WORD_BITS:0] diff;

   always_comb begin
      trial = {rem_i, qs_i[WORD_BITS-1]};
      diff  = trial - {1'b0, ud_i};
      if (!diff[WORD_BITS]) begin
         rem_o = diff[WORD_BITS-1:0];
         qs_o  = {qs_i[WORD_BITS-2:0], 1'b1};
      end else begin
         rem_o = trial[WORD_BITS-1:0];
         qs_o  = {qs_i[WORD_BITS-2:0], 1'b0};
      end
   end

endmodule

`default_nettype wire

>>> rtl/checked_integer_alu_top.sv
`default_nettype none

// Every request beat passes the prep stage, one divider stage per quotient bit
// and the output register; all commands take this path.
// Throughput: one beat per cycle; the whole pipeline holds while a response
// beat is stalled. Reset clears only the valid bits; data registers are free.
module checked_integer_alu_top #(
   parameter int WORD_BITS = cia_pkg::WORD_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cia_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cia_pkg::rsp_type      rsp_data
);

   localparam int W    = WORD_BITS;
   localparam int LO_B = W / 2;
   localparam int HI_B = W - LO_B;
   localparam int PW   = 2 * W;

   typedef struct packed {
      logic [1:0]   cmd;
      logic         exact;
      logic [W-1:0] res;
      logic         ovf;
      logic         qneg;
      logic         nneg;
      logic         dzero;
      logic [W-1:0] ud;
   } side_type;

   logic en;

   // pipeline registers, position 0 is the prep stage
   logic         vld_ff  [0:W];
   side_type     side_ff [0:W];
   logic [W-1:0] rem_ff  [0:W];
   logic [W-1:0] qs_ff   [0:W];

   // multiplier lane
   logic [W-1:0]       ma_ff, mb_ff;
   logic               mneg0_ff, mneg1_ff, mneg2_ff;
   logic [2*LO_B-1:0]  ll_ff;
   logic [W-1:0]       lh_ff, hl_ff;
   logic [2*HI_B-1:0]  hh_ff;
   logic [PW-1:0]      prod_ff;

   cia_pkg::rsp_type rsp_ff;
   logic             rsp_vld_ff;

   assign en        = !(rsp_vld_ff && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // prep: operand select, add/sub, magnitudes
   logic [W-1:0] a_w, b_w, x_w, y_w, s_w, n_w, d_w, un_w, ud_w;
   logic         s_ovf, mneg_w;
   side_type     side_in;

   always_comb begin
      a_w = req_data.operand_a[W-1:0];
      b_w = req_data.operand_b[W-1:0];
      x_w = req_data.swap_operands ? b_w : a_w;
      y_w = req_data.swap_operands ? a_w : b_w;
      if (req_data.command == cia_pkg::CMD_ADD) begin
         s_w   = a_w + b_w;
         s_ovf = ((a_w[W-1] ^ s_w[W-1]) & (b_w[W-1] ^ s_w[W-1]));
      end else begin
         s_w   = x_w - y_w;
         s_ovf = ((x_w[W-1] ^ y_w[W-1]) & (x_w[W-1] ^ s_w[W-1]));
      end
      n_w    = x_w;
      d_w    = y_w;
      un_w   = n_w[W-1] ? (~n_w + 1'b1) : n_w;
      ud_w   = d_w[W-1] ? (~d_w + 1'b1) : d_w;
      mneg_w = (a_w[W-1] != b_w[W-1]) && (a_w != '0) && (b_w != '0);
      side_in.cmd   = req_data.command;
      side_in.exact = req_data.exact_in;
      side_in.res   = s_w;
      side_in.ovf   = s_ovf;
      side_in.qneg  = n_w[W-1] != d_w[W-1];
      side_in.nneg  = n_w[W-1];
      side_in.dzero = d_w == '0;
      side_in.ud    = ud_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
      end
      if (en) begin
         side_ff[0] <= side_in;
         rem_ff[0]  <= '0;
         qs_ff[0]   <= un_w;
         ma_ff      <= a_w[W-1] ? (~a_w + 1'b1) : a_w;
         mb_ff      <= b_w[W-1] ? (~b_w + 1'b1) : b_w;
         mneg0_ff   <= mneg_w;
      end
   end

   // multiplier: partial products, then their sum
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= (2*LO_B)'(ma_ff[LO_B-1:0]) * (2*LO_B)'(mb_ff[LO_B-1:0]);
         lh_ff    <= W'(ma_ff[LO_B-1:0]) * W'(mb_ff[W-1:LO_B]);
         hl_ff    <= W'(ma_ff[W-1:LO_B]) * W'(mb_ff[LO_B-1:0]);
         hh_ff    <= (2*HI_B)'(ma_ff[W-1:LO_B]) * (2*HI_B)'(mb_ff[W-1:LO_B]);
         mneg1_ff <= mneg0_ff;
         prod_ff  <= (PW'(hh_ff) << (2*LO_B)) + ((PW'(lh_ff) + PW'(hl_ff)) << LO_B)
                     + PW'(ll_ff);
         mneg2_ff <= mneg1_ff;
      end
   end

   // multiply result and exact range check
   logic [W-1:0]  mul_res;
   logic [PW-1:0] mul_lim;
   logic          mul_ovf;

   always_comb begin
      mul_lim = (PW'(1) << (W - 1)) - PW'(!mneg2_ff);
      mul_ovf = prod_ff > mul_lim;
      mul_res = mneg2_ff ? (~prod_ff[W-1:0] + 1'b1) : prod_ff[W-1:0];
   end

   // divider stages, one quotient bit each
   for (genvar p = 1; p <= W; p++) begin : g_div
      logic [W-1:0] rem_in, qs_in;
      side_type     side_nx;

      cia_div_step #(.WORD_BITS(W)) u_step (
         .rem_i (rem_ff[p-1]),
         .qs_i  (qs_ff[p-1]),
         .ud_i  (side_ff[p-1].ud),
         .rem_o (rem_in),
         .qs_o  (qs_in)
      );

      always_comb begin
         side_nx = side_ff[p-1];
         if (p == 3 && side_ff[p-1].cmd == cia_pkg::CMD_MUL) begin
            side_nx.res = mul_res;
            side_nx.ovf = mul_ovf;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[p] <= 1'b0;
         end else if (en) begin
            vld_ff[p] <= vld_ff[p-1];
         end
         if (en) begin
            side_ff[p] <= side_nx;
            rem_ff[p]  <= rem_in;
            qs_ff[p]   <= qs_in;
         end
      end
   end

   // output stage: quotient and remainder signs, and status
   logic signed [W-1:0] res_s, rem_s;
   logic [1:0]          st;
   logic [W-1:0]        q_w, r_w;
   side_type            fin;

   always_comb begin
      fin   = side_ff[W];
      q_w   = qs_ff[W];
      r_w   = rem_ff[W];
      res_s = fin.res;
      rem_s = '0;
      st    = fin.ovf ? cia_pkg::ST_OVERFLOW : cia_pkg::ST_FITS;
      if (fin.cmd == cia_pkg::CMD_DIV) begin
         if (fin.dzero) begin
            res_s = '0;
            st    = cia_pkg::ST_DIVZERO;
         end else begin
            res_s = fin.qneg ? (~q_w + 1'b1) : q_w;
            rem_s = fin.nneg ? (~r_w + 1'b1) : r_w;
            if (!fin.qneg && q_w[W-1]) begin
               st = cia_pkg::ST_OVERFLOW;
            end else if (r_w != '0) begin
               st = cia_pkg::ST_INEXACT;
            end else begin
               st = cia_pkg::ST_FITS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= vld_ff[W];
      end
      if (en) begin
         rsp_ff.result    <= cia_pkg::DATA_BITS'(res_s);
         rsp_ff.remainder <= cia_pkg::DATA_BITS'(rem_s);
         rsp_ff.status    <= st;
         rsp_ff.exact_out <= fin.exact;
      end
   end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WB = cia_pkg::WORD_BITS_DEF;
   localparam int LATENCY = WB + 2;
   localparam int IDLE_LIMIT = 20000;

   // expected-result store and compare for the checked ALU
   class alu_scoreboard;
      cia_pkg::rsp_type pending[$];
      int      mismatches;
      int      checked;

      // signed extension of the low WB bits of an operand
      function logic [63:0] trim(logic [63:0] x);
         logic [63:0] m;
         m = (WB == 64) ? '1 : ((64'd1 << WB) - 64'd1);
         x = x & m;
         if (x[WB-1]) x = x | ~m;
         return x;
      endfunction

      function cia_pkg::rsp_type compute(cia_pkg::req_type r);
         cia_pkg::rsp_type o;
         logic [63:0] a, b, x, y, s, ua, ub, q, rm;
         logic [127:0] prod;
         logic        neg;
         logic signed [127:0] lo_lim, hi_lim, tv;
         o = '0;
         a = trim(r.operand_a);
         b = trim(r.operand_b);
         lo_lim = -(128'sd1 <<< (WB - 1));
         hi_lim = (128'sd1 <<< (WB - 1)) - 1;
         o.status = cia_pkg::ST_FITS;
         o.exact_out = r.exact_in;
         case (r.command)
            cia_pkg::CMD_ADD, cia_pkg::CMD_SUB: begin
               x = (r.command == cia_pkg::CMD_SUB && r.swap_operands) ? b : a;
               y = (r.command == cia_pkg::CMD_SUB && r.swap_operands) ? a : b;
               if (r.command == cia_pkg::CMD_ADD) tv = $signed(x) + $signed(y);
               else tv = $signed(x) - $signed(y);
               s = trim(tv[63:0]);
               o.result = s;
               if (tv < lo_lim || tv > hi_lim) o.status = cia_pkg::ST_OVERFLOW;
            end
            cia_pkg::CMD_MUL: begin
               ua = a[63] ? -a : a;
               ub = b[63] ? -b : b;
               prod = ua * ub;
               neg = (a[63] != b[63]) && a != 0 && b != 0;
               o.result = trim(a * b);
               if (neg ? (prod > (128'd1 << (WB - 1)))
                       : (prod > (128'd1 << (WB - 1)) - 1))
                  o.status = cia_pkg::ST_OVERFLOW;
            end
            default: begin
               x = r.swap_operands ? b : a;
               y = r.swap_operands ? a : b;
               if (y == 0) begin
                  o.status = cia_pkg::ST_DIVZERO;
               end else begin
                  ua = x[63] ? -x : x;
                  ub = y[63] ? -y : y;
                  q = ua / ub;
                  rm = ua % ub;
                  neg = x[63] != y[63];
                  o.result = trim(neg ? -q : q);
                  o.remainder = trim(x[63] ? -rm : rm);
                  if (!neg && q > (64'd1 << (WB - 1)) - 1) o.status = cia_pkg::ST_OVERFLOW;
                  else if (rm != 0) o.status = cia_pkg::ST_INEXACT;
               end
            end
         endcase
         return o;
      endfunction

      function void note_request(cia_pkg::req_type r);
         pending.push_back(compute(r));
      endfunction

      function void check_response(cia_pkg::rsp_type got);
         cia_pkg::rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %h %h st=%0d ex=%b got %h %h st=%0d ex=%b",
                  want.result, want.remainder, want.status, want.exact_out,
                  got.result, got.remainder, got.status, got.exact_out);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   cia_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1;
   cia_pkg::rsp_type rsp_data;

   alu_scoreboard board = new();
   int send_idle_pct = 38;
   int recv_idle_pct = 87;
   int hold_cycles = 0;
   int idle_count = 0;
   int sent = 0;

   checked_integer_alu_top u_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // accepted beats on both sides, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stall, with an optional long hold-off
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1;
      else if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function logic [63:0] pick_operand();
      case ($urandom_range(7))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return '1;
         3: return 64'd0;
         4: return {$urandom, $urandom} >> $urandom_range(63);
         5: return -({$urandom, $urandom} >> $urandom_range(63));
         6: return 64'(signed'($urandom_range(40)) - 20);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // one request beat, with random gaps before it; valid stays up for the next beat
   task automatic send_beat(cia_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_op(logic [1:0] c, logic [63:0] a, logic [63:0] b, logic sw);
      cia_pkg::req_type r;
      r.command = c;
      r.operand_a = a;
      r.operand_b = b;
      r.swap_operands = sw;
      r.exact_in = 1'($urandom_range(1));
      send_beat(r);
   endtask

   task automatic send_random(int n);
      cia_pkg::req_type r;
      repeat (n) begin
         r.command = 2'($urandom_range(3));
         r.operand_a = pick_operand();
         r.operand_b = pick_operand();
         if (r.command == cia_pkg::CMD_DIV && $urandom_range(3) == 0)
            r.operand_b = r.operand_a * $urandom_range(1, 5);
         r.swap_operands = 1'($urandom_range(1));
         r.exact_in = 1'($urandom_range(1));
         send_beat(r);
      end
   endtask

   // drop valid, then wait for every expected response
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   localparam logic [63:0] MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX = 64'h7fff_ffff_ffff_ffff;

   initial begin
      repeat (7) @(negedge clock);
      reset <= 0;

      // directed: extremes and the named corner cases
      send_op(cia_pkg::CMD_ADD, MAX, 64'd1, 0);
      send_op(cia_pkg::CMD_ADD, MIN, '1, 1);
      send_op(cia_pkg::CMD_ADD, MAX, MIN, 0);
      send_op(cia_pkg::CMD_SUB, MIN, 64'd1, 0);
      send_op(cia_pkg::CMD_SUB, 64'd1, MIN, 1);
      send_op(cia_pkg::CMD_SUB, 64'd5, 64'd9, 1);
      send_op(cia_pkg::CMD_MUL, MIN, '1, 0);
      send_op(cia_pkg::CMD_MUL, MIN, 64'd1, 1);
      send_op(cia_pkg::CMD_MUL, 64'h4000_0000_0000_0000, -64'd2, 0);
      send_op(cia_pkg::CMD_MUL, 64'h4000_0000_0000_0000, 64'd2, 0);
      send_op(cia_pkg::CMD_MUL, 64'd0, MIN, 0);
      send_op(cia_pkg::CMD_MUL, MAX, MAX, 0);
      send_op(cia_pkg::CMD_DIV, 64'd7, 64'd0, 0);
      send_op(cia_pkg::CMD_DIV, 64'd0, 64'd7, 1);
      send_op(cia_pkg::CMD_DIV, MIN, '1, 0);
      send_op(cia_pkg::CMD_DIV, '1, MIN, 1);
      send_op(cia_pkg::CMD_DIV, -64'd7, 64'd2, 0);
      send_op(cia_pkg::CMD_DIV, 64'd2, 64'd7, 1);
      send_op(cia_pkg::CMD_DIV, 64'd12, -64'd4, 0);
      send_op(cia_pkg::CMD_DIV, MAX, MIN, 0);
      drain();

      // long receiver hold-off while the sender keeps offering beats
      hold_cycles = 3 * LATENCY;
      send_idle_pct = 0;
      send_random(3 * LATENCY);
      drain();

      send_idle_pct = 38; recv_idle_pct = 87;
      send_random(350);
      send_idle_pct = 87; recv_idle_pct = 38;
      send_random(350);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      send_random(300);

      drain();
      repeat (LATENCY + 4) @(negedge clock);
      $display("sent %0d request beats, checked %0d response beats, %0d mismatches",
         sent, board.checked, board.mismatches);
      $display("ran overflow and divide corners, a long output hold-off, both idle mixes");
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
